// File: design/mlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_pkg: shared types and constants of the midpoint line rasterizer
// Word formats, step kind codes, queue status and back-end states.
// ----------------------------------------------------------------------------
package mlr_pkg;

	localparam int GRID_HALF_DEF = 15;
	localparam int COORD_MAX     = 30;

	localparam logic [1:0] KIND_FIRST = 2'd0;
	localparam logic [1:0] KIND_AXIAL = 2'd1;
	localparam logic [1:0] KIND_DIAG  = 2'd2;

	typedef struct packed {
		logic [4:0] start_x;
		logic [4:0] start_y;
		logic [4:0] end_x;
		logic [4:0] end_y;
	} seg_t;

	typedef struct packed {
		logic [4:0] cell_x;
		logic [4:0] cell_y;
		logic [1:0] step_kind;
		logic       last_cell;
	} cell_t;

	// classified segment, as handed from front to back
	typedef struct packed {
		logic [4:0]        x0;
		logic [4:0]        y0;
		logic              sx_neg;
		logic              sy_neg;
		logic              x_major;
		logic [4:0]        major;
		logic signed [7:0] d0;
		logic signed [7:0] inc_axial;
		logic signed [7:0] inc_diag;
	} desc_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} back_state_t;

endpackage
`default_nettype wire

// File: design/mlr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_front: segment intake and classification
// Saturates endpoints, derives deltas, major axis and decision terms.
// ----------------------------------------------------------------------------
module mlr_front import mlr_pkg::*; #(
	parameter int GRID_HALF = GRID_HALF_DEF
) (
	input  wire logic    start,
	input  wire seg_t    seg,
	input  wire q_stat_t q_stat,
	output logic         busy,
	output logic         push,
	output desc_t        desc
);

	localparam int CoordLimit = (2 * GRID_HALF < COORD_MAX) ? 2 * GRID_HALF : COORD_MAX;
	localparam logic [4:0] LIMIT = CoordLimit[4:0];

	logic [4:0]        x0, y0, x1, y1;
	logic signed [5:0] dx, dy;
	logic [4:0]        adx, ady;
	logic              x_major;
	logic [4:0]        major, minor;
	logic [7:0]        two_minor, two_major;

	function automatic logic [4:0] clamp(input logic [4:0] v);
		clamp = (v > LIMIT) ? LIMIT : v;
	endfunction

	always_comb begin
		x0 = clamp(seg.start_x);
		y0 = clamp(seg.start_y);
		x1 = clamp(seg.end_x);
		y1 = clamp(seg.end_y);
		dx = $signed({1'b0, x1}) - $signed({1'b0, x0});
		dy = $signed({1'b0, y1}) - $signed({1'b0, y0});
		adx = dx[5] ? 5'(-dx) : dx[4:0];
		ady = dy[5] ? 5'(-dy) : dy[4:0];
		x_major = adx > ady;
		major = x_major ? adx : ady;
		minor = x_major ? ady : adx;
		two_minor = {2'b00, minor, 1'b0};
		two_major = {2'b00, major, 1'b0};

		desc.x0        = x0;
		desc.y0        = y0;
		desc.sx_neg    = dx[5];
		desc.sy_neg    = dy[5];
		desc.x_major   = x_major;
		desc.major     = major;
		desc.d0        = $signed(two_minor - {3'b000, major});
		desc.inc_axial = $signed(two_minor);
		desc.inc_diag  = $signed(two_minor - two_major);
	end

	assign busy = q_stat.full;
	assign push = start && !q_stat.full;

endmodule
`default_nettype wire

// File: design/mlr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_queue: two-entry segment queue
// Decouples intake from the cell stepper.
// ----------------------------------------------------------------------------
module mlr_queue import mlr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t wr_desc,
	input  wire logic  pop,
	output desc_t      rd_desc,
	output q_stat_t    q_stat
);

	desc_t      mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign rd_desc      = mem_q[rd_ptr_q];
	assign q_stat.empty = (count_q == 2'd0);
	assign q_stat.full  = (count_q == 2'd2);

endmodule
`default_nettype wire

// File: design/mlr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_back: midpoint cell stepper
// Walks one queued segment a cell per cycle and registers each word.
// ----------------------------------------------------------------------------
module mlr_back import mlr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_stat_t q_stat,
	input  wire desc_t   rd_desc,
	output logic         pop,
	output logic         cell_valid,
	output cell_t        cell_word
);

	back_state_t       state_q, state_d;
	desc_t             cur_q;
	logic [4:0]        x_q, y_q, rem_q;
	logic signed [7:0] d_q;
	logic [1:0]        kind_q;
	logic              valid_q;
	cell_t             cell_q;
	logic              last;
	logic              step_x, step_y;

	assign last = (rem_q == 5'd0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (last && q_stat.empty) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		pop = 1'b0;
		case (state_q)
			ST_IDLE: pop = !q_stat.empty;
			ST_RUN:  pop = last && !q_stat.empty;
			default: pop = 1'b0;
		endcase
	end

	// negative decision: axial step along the major axis only
	assign step_x = !d_q[7] || cur_q.x_major;
	assign step_y = !d_q[7] || !cur_q.x_major;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= (state_q == ST_RUN);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			cell_q.cell_x    <= x_q;
			cell_q.cell_y    <= y_q;
			cell_q.step_kind <= kind_q;
			cell_q.last_cell <= last;
		end
		if (pop) begin
			cur_q  <= rd_desc;
			x_q    <= rd_desc.x0;
			y_q    <= rd_desc.y0;
			d_q    <= rd_desc.d0;
			rem_q  <= rd_desc.major;
			kind_q <= KIND_FIRST;
		end else if (state_q == ST_RUN && !last) begin
			if (step_x) begin
				x_q <= cur_q.sx_neg ? x_q - 5'd1 : x_q + 5'd1;
			end
			if (step_y) begin
				y_q <= cur_q.sy_neg ? y_q - 5'd1 : y_q + 5'd1;
			end
			d_q    <= d_q + (d_q[7] ? cur_q.inc_axial : cur_q.inc_diag);
			kind_q <= d_q[7] ? KIND_AXIAL : KIND_DIAG;
			rem_q  <= rem_q - 5'd1;
		end
	end

	assign cell_valid = valid_q;
	assign cell_word  = cell_q;

endmodule
`default_nettype wire

// File: design/midpoint_line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// When the stepper is idle, the first cell word of a segment passes the queue entry,
// the stepper registers and the output register. A segment has max(|dx|,|dy|)+1
// cells (up to 31); the stepper issues one cell per cycle, and a queued segment
// follows with no gap, else the stepper first passes through its idle state. busy
// rises while two segments wait in the queue. The receiver cannot stall: each word
// is strobed once. Reset (arst_n low) empties the queue, idles the stepper at once.
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer: Bresenham line cell generator
// Takes a segment between two grid endpoints and emits each line cell in order.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer import mlr_pkg::*; #(
	parameter int GRID_HALF = GRID_HALF_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire seg_t seg,
	output logic      busy,
	output logic      cell_valid,
	output cell_t     cell_word
);

	// front to queue
	logic    push;
	desc_t   wr_desc;
	// queue to back
	desc_t   rd_desc;
	q_stat_t q_stat;
	logic    pop;

	// Front: saturate the endpoints, pick the major axis and prepare the
	// decision variable and its two increments; push one word per segment.
	mlr_front #(
		.GRID_HALF(GRID_HALF)
	) u_front (
		.start (start),
		.seg   (seg),
		.q_stat(q_stat),
		.busy  (busy),
		.push  (push),
		.desc  (wr_desc)
	);

	// Queue: hold up to two classified segments so intake runs ahead of
	// the stepper.
	mlr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_desc(wr_desc),
		.pop    (pop),
		.rd_desc(rd_desc),
		.q_stat (q_stat)
	);

	// Back: advance one cell per cycle, axial on a negative decision and
	// diagonal otherwise, and register each cell word for the receiver.
	mlr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.rd_desc   (rd_desc),
		.pop       (pop),
		.cell_valid(cell_valid),
		.cell_word (cell_word)
	);

endmodule
`default_nettype wire

// File: design/mlr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_checker: port-level checks of the rasterizer
// Cells of one segment are contiguous and adjacent on the grid.
// ----------------------------------------------------------------------------
module mlr_checker import mlr_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  cell_valid,
	input wire cell_t cell_word
);

	// hold the next cell of an unfinished segment in the following cycle
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_word.last_cell |=> cell_valid &&
			cell_word.step_kind != KIND_FIRST)
		else $error("segment cells not contiguous");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid |-> (cell_word.step_kind == KIND_FIRST ||
			cell_word.step_kind == KIND_AXIAL || cell_word.step_kind == KIND_DIAG))
		else $error("bad step kind");

	a_adjacent_x: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_word.last_cell |=>
			(cell_word.cell_x == $past(cell_word.cell_x) ||
			cell_word.cell_x == $past(cell_word.cell_x) + 5'd1 ||
			cell_word.cell_x == $past(cell_word.cell_x) - 5'd1))
		else $error("column jump");

	a_adjacent_y: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_word.last_cell |=>
			(cell_word.cell_y == $past(cell_word.cell_y) ||
			cell_word.cell_y == $past(cell_word.cell_y) + 5'd1 ||
			cell_word.cell_y == $past(cell_word.cell_y) - 5'd1))
		else $error("row jump");

	a_diag_moves: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_word.last_cell |=> cell_word.step_kind != KIND_DIAG ||
			(cell_word.cell_x != $past(cell_word.cell_x) &&
			cell_word.cell_y != $past(cell_word.cell_y)))
		else $error("diagonal step did not move both axes");

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cell_valid(cell_valid),
	.cell_word (cell_word)
);
`default_nettype wire
